// ===== sv/plu_pkg.sv =====
// Shared types and constants for the Phong lighting unit.
// Used by every module of the block; depends on nothing.
`default_nettype none
package plu_pkg;

   // default parameter values
   localparam int COMPONENT_WIDTH_DEF = 16;
   localparam int EXPONENT_BITS_DEF   = 8;

   // fixed-point formats
   localparam int COLOR_W    = 16;
   localparam int FRAC_Q     = 12;
   localparam int DIST_W     = 24;
   localparam int RGB_W      = 3 * COLOR_W;
   localparam int COEF_W     = 2 * COLOR_W - FRAC_Q;
   localparam int DIF_W      = COEF_W + COLOR_W - FRAC_Q;
   localparam int SUM_W      = DIF_W + 1;
   localparam int DSQ_W      = 2 * DIST_W;
   localparam int QUO_W      = COLOR_W;
   localparam int REM_W      = 64;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = RGB_W;

   localparam logic [COLOR_W-1:0] SAT_VAL = {COLOR_W{1'b1}};
   localparam logic [COLOR_W-1:0] ONE_VAL = COLOR_W'(1 << FRAC_Q);

   // configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_AMBIENT  = 2'd0,
      CSR_DIFFUSE  = 2'd1,
      CSR_SPECULAR = 2'd2,
      CSR_ATTEN    = 2'd3
   } csr_idx_type;

   // per-channel terms carried through the power chain
   typedef struct packed {
      logic [2:0][COEF_W-1:0] amb;
      logic [2:0][DIF_W-1:0]  dif;
      logic [2:0][COEF_W-1:0] spc;
      logic [DSQ_W-1:0]       dsq;
   } shade_type;

   // running power and its base
   typedef struct packed {
      logic [COLOR_W-1:0] p;
      logic [COLOR_W-1:0] d;
   } pow_type;

   // divider state per channel
   typedef struct packed {
      logic [2:0][COEF_W-1:0] amb;
      logic [2:0][REM_W-1:0]  rem;
      logic [2:0][QUO_W-1:0]  quo;
      logic [2:0]             ovf;
      logic [DSQ_W-1:0]       dsq;
      logic                   use_div;
   } div_type;

endpackage
`default_nettype wire

// ===== sv/plu_front.sv =====
// Front end of the Phong lighting unit: dot products, Q4.12 scaling and
// colour coefficients over three register stages. Depends on plu_pkg.
`default_nettype none
module plu_front #(
   parameter int COMPONENT_WIDTH = plu_pkg::COMPONENT_WIDTH_DEF,
   parameter int EXPONENT_BITS   = plu_pkg::EXPONENT_BITS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                en,
   input  wire logic                                in_valid,
   input  wire logic [3*COMPONENT_WIDTH-1:0]        light_dir,
   input  wire logic [3*COMPONENT_WIDTH-1:0]        surface_normal,
   input  wire logic [3*COMPONENT_WIDTH-1:0]        reflected_dir,
   input  wire logic [3*COMPONENT_WIDTH-1:0]        view_dir,
   input  wire logic [plu_pkg::RGB_W-1:0]           mat_ambient,
   input  wire logic [plu_pkg::RGB_W-1:0]           mat_diffuse,
   input  wire logic [plu_pkg::RGB_W-1:0]           mat_specular,
   input  wire logic [EXPONENT_BITS-1:0]            shininess,
   input  wire logic [plu_pkg::DIST_W-1:0]          light_distance,
   input  wire logic                                in_shadow,
   input  wire logic [plu_pkg::RGB_W-1:0]           light_ambient,
   input  wire logic [plu_pkg::RGB_W-1:0]           light_diffuse,
   input  wire logic [plu_pkg::RGB_W-1:0]           light_specular,
   output logic                                     out_valid,
   output plu_pkg::shade_type                       out_shade,
   output plu_pkg::pow_type                         out_pow,
   output logic [EXPONENT_BITS-1:0]                 out_expo
);

   localparam int CW = COMPONENT_WIDTH;
   localparam int PW = 2 * CW;
   localparam int SW = PW + 2;
   localparam int SH = PW - 16;
   localparam int TW = SW - SH;
   localparam int CPW = 2 * plu_pkg::COLOR_W;
   localparam int DPW = plu_pkg::COEF_W + plu_pkg::COLOR_W;

   // non-negative dot to Q4.12, truncated and saturated
   function automatic logic [plu_pkg::COLOR_W-1:0] dot_q12(input logic signed [SW-1:0] s);
      logic [TW-1:0] sh;
      sh = s[SW-1:SH];
      if (s[SW-1] || s == '0) dot_q12 = '0;
      else if (|sh[TW-1:plu_pkg::COLOR_W]) dot_q12 = plu_pkg::SAT_VAL;
      else dot_q12 = sh[plu_pkg::COLOR_W-1:0];
   endfunction

   logic                          v1_ff, v2_ff, v3_ff;
   logic signed [PW-1:0]          ld_prod_ff [3];
   logic signed [PW-1:0]          rv_prod_ff [3];
   logic [CPW-1:0]                camb_ff [3];
   logic [CPW-1:0]                cdif_ff [3];
   logic [CPW-1:0]                cspc_ff [3];
   logic [plu_pkg::DIST_W-1:0]    dist1_ff, dist2_ff;
   logic                          shadow1_ff;
   logic [EXPONENT_BITS-1:0]      expo1_ff, expo2_ff, expo3_ff;
   logic [plu_pkg::COEF_W-1:0]    amb2_ff [3];
   logic [plu_pkg::COEF_W-1:0]    difc2_ff [3];
   logic [plu_pkg::COEF_W-1:0]    spcc2_ff [3];
   logic [plu_pkg::COLOR_W-1:0]   ddif2_ff, dspc2_ff;
   logic                          spon2_ff;
   plu_pkg::shade_type            shade3_ff;
   plu_pkg::pow_type              pow3_ff;

   logic signed [SW-1:0]          sum_ld, sum_rv;
   logic [DPW-1:0]                dif_prod [3];

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   // stage 1: component and colour products
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            ld_prod_ff[i] <= $signed(light_dir[i*CW +: CW]) * $signed(surface_normal[i*CW +: CW]);
            rv_prod_ff[i] <= $signed(reflected_dir[i*CW +: CW]) * $signed(view_dir[i*CW +: CW]);
            camb_ff[i] <= CPW'(light_ambient[i*16 +: 16]) * CPW'(mat_ambient[i*16 +: 16]);
            cdif_ff[i] <= CPW'(light_diffuse[i*16 +: 16]) * CPW'(mat_diffuse[i*16 +: 16]);
            cspc_ff[i] <= CPW'(light_specular[i*16 +: 16]) * CPW'(mat_specular[i*16 +: 16]);
         end
         dist1_ff   <= light_distance;
         shadow1_ff <= in_shadow;
         expo1_ff   <= shininess;
      end
   end

   // dot sums
   always_comb begin
      sum_ld = SW'(ld_prod_ff[0]) + SW'(ld_prod_ff[1]) + SW'(ld_prod_ff[2]);
      sum_rv = SW'(rv_prod_ff[0]) + SW'(rv_prod_ff[1]) + SW'(rv_prod_ff[2]);
   end

   // stage 2: scaled dots and colour coefficients
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            amb2_ff[i]  <= camb_ff[i][CPW-1:plu_pkg::FRAC_Q];
            difc2_ff[i] <= cdif_ff[i][CPW-1:plu_pkg::FRAC_Q];
            spcc2_ff[i] <= cspc_ff[i][CPW-1:plu_pkg::FRAC_Q];
         end
         ddif2_ff <= shadow1_ff ? '0 : dot_q12(sum_ld);
         dspc2_ff <= dot_q12(sum_rv);
         spon2_ff <= !shadow1_ff && !sum_rv[SW-1];
         dist2_ff <= dist1_ff;
         expo2_ff <= expo1_ff;
      end
   end

   // diffuse products
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         dif_prod[i] = DPW'(difc2_ff[i]) * DPW'(ddif2_ff);
      end
   end

   // stage 3: diffuse term, distance squared, power seed
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            shade3_ff.amb[i] <= amb2_ff[i];
            shade3_ff.spc[i] <= spcc2_ff[i];
            shade3_ff.dif[i] <= dif_prod[i][DPW-1:plu_pkg::FRAC_Q];
         end
         shade3_ff.dsq <= plu_pkg::DSQ_W'(dist2_ff) * plu_pkg::DSQ_W'(dist2_ff);
         pow3_ff.p <= spon2_ff ? plu_pkg::ONE_VAL : '0;
         pow3_ff.d <= dspc2_ff;
         expo3_ff  <= expo2_ff;
      end
   end

   assign out_valid = v3_ff;
   assign out_shade = shade3_ff;
   assign out_pow   = pow3_ff;
   assign out_expo  = expo3_ff;

endmodule
`default_nettype wire

// ===== sv/plu_pow_stage.sv =====
// One step of the specular power chain: p = min((p*d) >> 12, 0xFFFF) when
// the step number is below the exponent. Depends on plu_pkg.
`default_nettype none
module plu_pow_stage #(
   parameter int EXPONENT_BITS = plu_pkg::EXPONENT_BITS_DEF,
   parameter int STEP          = 0
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     en,
   input  wire logic                     in_valid,
   input  wire logic [EXPONENT_BITS-1:0] in_expo,
   input  plu_pkg::pow_type              in_pow,
   input  plu_pkg::shade_type            in_shade,
   output logic                          out_valid,
   output logic [EXPONENT_BITS-1:0]      out_expo,
   output plu_pkg::pow_type              out_pow,
   output plu_pkg::shade_type            out_shade
);

   localparam int PW = 2 * plu_pkg::COLOR_W;

   logic                      valid_ff;
   logic [EXPONENT_BITS-1:0]  expo_ff;
   plu_pkg::pow_type          pow_ff;
   plu_pkg::shade_type        shade_ff;
   logic [PW-1:0]             prod;
   logic [plu_pkg::COLOR_W-1:0] p_in;

   // one multiply and saturate
   always_comb begin
      prod = PW'(in_pow.p) * PW'(in_pow.d);
      if (in_expo > EXPONENT_BITS'(STEP)) begin
         if (|prod[PW-1:plu_pkg::FRAC_Q+plu_pkg::COLOR_W]) p_in = plu_pkg::SAT_VAL;
         else p_in = prod[plu_pkg::FRAC_Q+plu_pkg::COLOR_W-1:plu_pkg::FRAC_Q];
      end else begin
         p_in = in_pow.p;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else if (en) valid_ff <= in_valid;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         expo_ff   <= in_expo;
         pow_ff.p  <= p_in;
         pow_ff.d  <= in_pow.d;
         shade_ff  <= in_shade;
      end
   end

   assign out_valid = valid_ff;
   assign out_expo  = expo_ff;
   assign out_pow   = pow_ff;
   assign out_shade = shade_ff;

endmodule
`default_nettype wire

// ===== sv/plu_div_stage.sv =====
// One restoring step of the attenuation divider, one quotient bit per
// channel. Depends on plu_pkg.
`default_nettype none
module plu_div_stage #(
   parameter int STEP = 0
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        en,
   input  wire logic        in_valid,
   input  plu_pkg::div_type in_div,
   output logic             out_valid,
   output plu_pkg::div_type out_div
);

   logic                    valid_ff;
   plu_pkg::div_type        div_ff;
   plu_pkg::div_type        div_in;
   logic [plu_pkg::REM_W-1:0] divisor;

   // trial subtract of the shifted divisor
   always_comb begin
      div_in  = in_div;
      divisor = plu_pkg::REM_W'(in_div.dsq) << STEP;
      for (int i = 0; i < 3; i++) begin
         if (in_div.use_div && in_div.rem[i] >= divisor) begin
            div_in.rem[i]       = in_div.rem[i] - divisor;
            div_in.quo[i][STEP] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else if (en) valid_ff <= in_valid;
   end

   always_ff @(posedge clock) begin
      if (en) div_ff <= div_in;
   end

   assign out_valid = valid_ff;
   assign out_div   = div_ff;

endmodule
`default_nettype wire

// ===== sv/phong_lighting_unit.sv =====
// Phong lighting unit: one shaded point per cycle while the skid slot is
// empty, with every stage held while it is full. The specular power chain
// of 2**EXPONENT_BITS - 1 multiply stages and the 16-step attenuation divider
// set the latency; an output register with a skid slot keeps req_tready high
// while one result waits. Depends on plu_pkg, plu_front, plu_pow_stage and
// plu_div_stage.
`default_nettype none
module phong_lighting_unit #(
   parameter int COMPONENT_WIDTH = plu_pkg::COMPONENT_WIDTH_DEF,
   parameter int EXPONENT_BITS   = plu_pkg::EXPONENT_BITS_DEF,
   localparam int OFF_LD  = 0,
   localparam int OFF_SN  = 3 * COMPONENT_WIDTH,
   localparam int OFF_RD  = 6 * COMPONENT_WIDTH,
   localparam int OFF_VD  = 9 * COMPONENT_WIDTH,
   localparam int OFF_MA  = 12 * COMPONENT_WIDTH,
   localparam int OFF_MD  = OFF_MA + plu_pkg::RGB_W,
   localparam int OFF_MS  = OFF_MD + plu_pkg::RGB_W,
   localparam int OFF_SH  = OFF_MS + plu_pkg::RGB_W,
   localparam int OFF_DI  = OFF_SH + EXPONENT_BITS,
   localparam int REQ_BITS = OFF_DI + plu_pkg::DIST_W,
   localparam int REQ_W   = ((REQ_BITS + 7) / 8) * 8
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   // light_dir, surface_normal, reflected_dir, view_dir, mat_ambient,
   // mat_diffuse, mat_specular, shininess, light_distance
   input  wire logic [REQ_W-1:0]                 req_tdata,
   // in_shadow
   input  wire logic                             req_tuser,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   // red, green, blue
   output logic [plu_pkg::RGB_W-1:0]             rsp_tdata,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [plu_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [plu_pkg::CSR_DATA_W-1:0]   csr_data
);

   localparam int MAXE = (1 << EXPONENT_BITS) - 1;
   localparam int SPW  = plu_pkg::COEF_W + plu_pkg::COLOR_W;
   localparam int TOT_W = plu_pkg::COEF_W + 1;

   // configuration registers
   logic [plu_pkg::RGB_W-1:0] light_ambient_ff, light_diffuse_ff, light_specular_ff;
   logic                      atten_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         light_ambient_ff  <= '0;
         light_diffuse_ff  <= '0;
         light_specular_ff <= '0;
         atten_ff          <= 1'b0;
      end else if (csr_valid) begin
         unique case (plu_pkg::csr_idx_type'(csr_index))
            plu_pkg::CSR_AMBIENT:  light_ambient_ff  <= csr_data;
            plu_pkg::CSR_DIFFUSE:  light_diffuse_ff  <= csr_data;
            plu_pkg::CSR_SPECULAR: light_specular_ff <= csr_data;
            plu_pkg::CSR_ATTEN:    atten_ff          <= csr_data[0];
            default: ;
         endcase
      end
   end

   // pipeline advance: held only while the skid slot is full
   logic skid_valid_ff, skid_valid_in;
   logic out_valid_ff, out_valid_in;
   logic en;

   assign en         = !skid_valid_ff;
   assign req_tready = en;

   // power chain links
   logic                      pv [MAXE+1];
   logic [EXPONENT_BITS-1:0]  pe [MAXE+1];
   plu_pkg::pow_type          pp [MAXE+1];
   plu_pkg::shade_type        ps [MAXE+1];

   plu_front #(
      .COMPONENT_WIDTH (COMPONENT_WIDTH),
      .EXPONENT_BITS   (EXPONENT_BITS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .en             (en),
      .in_valid       (req_tvalid),
      .light_dir      (req_tdata[OFF_LD +: 3*COMPONENT_WIDTH]),
      .surface_normal (req_tdata[OFF_SN +: 3*COMPONENT_WIDTH]),
      .reflected_dir  (req_tdata[OFF_RD +: 3*COMPONENT_WIDTH]),
      .view_dir       (req_tdata[OFF_VD +: 3*COMPONENT_WIDTH]),
      .mat_ambient    (req_tdata[OFF_MA +: plu_pkg::RGB_W]),
      .mat_diffuse    (req_tdata[OFF_MD +: plu_pkg::RGB_W]),
      .mat_specular   (req_tdata[OFF_MS +: plu_pkg::RGB_W]),
      .shininess      (req_tdata[OFF_SH +: EXPONENT_BITS]),
      .light_distance (req_tdata[OFF_DI +: plu_pkg::DIST_W]),
      .in_shadow      (req_tuser),
      .light_ambient  (light_ambient_ff),
      .light_diffuse  (light_diffuse_ff),
      .light_specular (light_specular_ff),
      .out_valid      (pv[0]),
      .out_shade      (ps[0]),
      .out_pow        (pp[0]),
      .out_expo       (pe[0])
   );

   // specular power chain, one step per stage
   for (genvar k = 0; k < MAXE; k++) begin : g_pow
      plu_pow_stage #(
         .EXPONENT_BITS (EXPONENT_BITS),
         .STEP          (k)
      ) u_pow (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (pv[k]),
         .in_expo   (pe[k]),
         .in_pow    (pp[k]),
         .in_shade  (ps[k]),
         .out_valid (pv[k+1]),
         .out_expo  (pe[k+1]),
         .out_pow   (pp[k+1]),
         .out_shade (ps[k+1])
      );
   end

   // specular term
   logic                        va_ff, vb_ff;
   logic [SPW-1:0]              spe_prod [3];
   logic [plu_pkg::DIF_W-1:0]   spe_ff [3];
   logic [plu_pkg::DIF_W-1:0]   difa_ff [3];
   logic [plu_pkg::COEF_W-1:0]  amba_ff [3];
   logic [plu_pkg::DSQ_W-1:0]   dsqa_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         spe_prod[i] = SPW'(ps[MAXE].spc[i]) * SPW'(pp[MAXE].p);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
      end else if (en) begin
         va_ff <= pv[MAXE];
         vb_ff <= va_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            spe_ff[i]  <= spe_prod[i][SPW-1:plu_pkg::FRAC_Q];
            difa_ff[i] <= ps[MAXE].dif[i];
            amba_ff[i] <= ps[MAXE].amb[i];
         end
         dsqa_ff <= ps[MAXE].dsq;
      end
   end

   // sum of terms and divider set-up
   logic [plu_pkg::SUM_W-1:0] lit_sum [3];
   plu_pkg::div_type          prep_in, prep_ff;

   always_comb begin
      prep_in.dsq     = dsqa_ff;
      prep_in.use_div = atten_ff && (dsqa_ff != '0);
      for (int i = 0; i < 3; i++) begin
         lit_sum[i] = plu_pkg::SUM_W'(difa_ff[i]) + plu_pkg::SUM_W'(spe_ff[i]);
         prep_in.amb[i] = amba_ff[i];
         prep_in.rem[i] = plu_pkg::REM_W'({lit_sum[i], 24'd0});
         if (prep_in.use_div) begin
            prep_in.ovf[i] = plu_pkg::DSQ_W'({lit_sum[i], 8'd0}) >= dsqa_ff;
            prep_in.quo[i] = '0;
         end else begin
            prep_in.ovf[i] = |lit_sum[i][plu_pkg::SUM_W-1:plu_pkg::QUO_W];
            prep_in.quo[i] = lit_sum[i][plu_pkg::QUO_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) prep_ff <= prep_in;
   end

   // attenuation divider, most significant quotient bit first
   logic             dv [plu_pkg::QUO_W+1];
   plu_pkg::div_type dd [plu_pkg::QUO_W+1];

   assign dv[0] = vb_ff;
   assign dd[0] = prep_ff;

   for (genvar j = 0; j < plu_pkg::QUO_W; j++) begin : g_div
      plu_div_stage #(
         .STEP (plu_pkg::QUO_W - 1 - j)
      ) u_div (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (dv[j]),
         .in_div    (dd[j]),
         .out_valid (dv[j+1]),
         .out_div   (dd[j+1])
      );
   end

   // final add and saturate
   logic [plu_pkg::RGB_W-1:0] fin_data;
   logic [TOT_W-1:0]          total [3];
   logic                      fin_valid;

   assign fin_valid = dv[plu_pkg::QUO_W];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         total[i] = TOT_W'(dd[plu_pkg::QUO_W].amb[i]) + TOT_W'(dd[plu_pkg::QUO_W].quo[i]);
         if (dd[plu_pkg::QUO_W].ovf[i] || |total[i][TOT_W-1:plu_pkg::COLOR_W])
            fin_data[i*plu_pkg::COLOR_W +: plu_pkg::COLOR_W] = plu_pkg::SAT_VAL;
         else
            fin_data[i*plu_pkg::COLOR_W +: plu_pkg::COLOR_W] = total[i][plu_pkg::COLOR_W-1:0];
      end
   end

   // output register with skid slot
   logic [plu_pkg::RGB_W-1:0] out_data_ff, out_data_in;
   logic [plu_pkg::RGB_W-1:0] skid_data_ff, skid_data_in;
   logic                      out_free;

   always_comb begin
      out_free      = !out_valid_ff || rsp_tready;
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in  = fin_valid;
            out_data_in   = fin_data;
         end
      end else if (fin_valid && en) begin
         skid_valid_in = 1'b1;
         skid_data_in  = fin_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule
`default_nettype wire
